@@ sv/rxmon_pkg.sv @@
// Shared types, constants and helper functions of the CAN receive timeout monitor.
package rxmon_pkg;

	localparam int ENTRIES_DEF   = 16;
	localparam int ID_W          = 29;
	localparam int DATA_W        = 64;
	localparam int TMO_W         = 16;
	localparam int CNT_W         = 21;
	localparam int LIMIT_W       = 20;
	localparam int DLC_W         = 4;
	localparam int IDX_W         = 4;
	localparam int MAP_W         = 16;
	localparam int ACTIVE_W      = 5;
	localparam int TIMEOUT_SCALE = 10;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	// Item function codes
	localparam logic [1:0] FUNC_LOAD = 2'd0;
	localparam logic [1:0] FUNC_RECV = 2'd1;
	localparam logic [1:0] FUNC_TICK = 2'd2;
	localparam logic [1:0] FUNC_READ = 2'd3;

	typedef struct packed {
		logic [1:0]        func;
		logic [ID_W-1:0]   frame_id;
		logic [DLC_W-1:0]  byte_count;
		logic [DATA_W-1:0] payload;
		logic [IDX_W-1:0]  entry_index;
		logic [TMO_W-1:0]  timeout_units;
		logic [TMO_W-1:0]  elapsed;
	} item_t;

	typedef struct packed {
		logic              matched;
		logic [IDX_W-1:0]  match_index;
		logic [MAP_W-1:0]  timeout_map;
		logic [DATA_W-1:0] entry_data;
		logic              entry_received;
		logic              entry_timed_out;
	} result_t;

	// Identifier and timeout of one mailbox entry
	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [TMO_W-1:0] tmo;
	} id_entry_t;

	// Data bytes and elapsed counter of one mailbox entry
	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic [CNT_W-1:0]  count;
	} data_entry_t;

	// Counter update of one tick: flag set on expiry, new counter value
	typedef struct packed {
		logic             expired;
		logic [CNT_W-1:0] count;
	} tick_res_t;

	// Replace the first dlc bytes of old with payload bytes; longer codes copy all 8
	function automatic logic [DATA_W-1:0] merge_bytes(
		input logic [DATA_W-1:0] old_data,
		input logic [DATA_W-1:0] new_data,
		input logic [DLC_W-1:0]  dlc
	);
		logic [DATA_W-1:0] res;
		res = old_data;
		for (int k = 0; k < DATA_W / 8; k++) begin
			if (DLC_W'(k) < dlc) begin
				res[k*8 +: 8] = new_data[k*8 +: 8];
			end
		end
		return res;
	endfunction

	// Add elapsed time, saturate, and compare against ten times the timeout
	function automatic tick_res_t tick_update(
		input logic [CNT_W-1:0] count,
		input logic [TMO_W-1:0] dt,
		input logic [TMO_W-1:0] tmo
	);
		logic [CNT_W:0]     sum;
		logic [CNT_W-1:0]   sat;
		logic [LIMIT_W-1:0] limit;
		tick_res_t          res;
		sum   = {1'b0, count} + (CNT_W + 1)'(dt);
		sat   = sum[CNT_W] ? COUNT_MAX : sum[CNT_W-1:0];
		limit = LIMIT_W'(tmo) * LIMIT_W'(TIMEOUT_SCALE);
		if (sat > CNT_W'(limit)) begin
			res.expired = 1'b1;
			res.count   = '0;
		end else begin
			res.expired = 1'b0;
			res.count   = sat;
		end
		return res;
	endfunction

endpackage

@@ sv/rxmon_id_ram.sv @@
// Identifier and timeout memory: one write port, one registered read port.
module rxmon_id_ram #(
	parameter int ENTRIES = rxmon_pkg::ENTRIES_DEF,
	parameter int IW      = 4
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [IW-1:0]      wr_addr,
	input  rxmon_pkg::id_entry_t wr_entry,
	input  logic               rd_en,
	input  logic [IW-1:0]      rd_addr,
	output rxmon_pkg::id_entry_t rd_entry
);
	import rxmon_pkg::*;

	id_entry_t mem_q [ENTRIES];
	id_entry_t rd_q;

	// Write and read the entry array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_entry = rd_q;

endmodule

@@ sv/rxmon_data_ram.sv @@
// Data and elapsed counter memory with per-entry valid bits standing in for reset.
module rxmon_data_ram #(
	parameter int ENTRIES = rxmon_pkg::ENTRIES_DEF,
	parameter int IW      = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [IW-1:0]          wr_addr,
	input  rxmon_pkg::data_entry_t wr_entry,
	input  logic                   rd_en,
	input  logic [IW-1:0]          rd_addr,
	output rxmon_pkg::data_entry_t rd_entry
);
	import rxmon_pkg::*;

	data_entry_t        mem_q [ENTRIES];
	data_entry_t        rd_q;
	logic [ENTRIES-1:0] vld_q;
	logic               rd_vld_q;

	// Write and read the entry array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	// Mark written entries; an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_entry = rd_vld_q ? rd_q : '0;

endmodule

@@ sv/can_rx_mailbox_timeout_monitor_top.sv @@
// Top level of the CAN receive mailbox table with per-entry timeout supervision.
//
// Items arrive on the item channel (item_valid / item_stall) and each gives
// exactly one result on the result channel (result_valid / result_stall).
// The cfg channel (cfg_valid / cfg_ready, always ready) writes active_entries;
// write it only while no item is in flight.
// A load writes the identifier memory at acceptance and a read item makes one
// registered read. Receive and tick walk the identifier/timeout memory and the
// data/counter memory over the active entries, one entry per cycle through
// their single read port; a receive stops at the first hit, and a tick writes
// each entry back in the cycle after its read.
// One item is worked on at a time. A new item is taken as soon as the previous
// one has its result registered, even while that result is stalled; a held
// result blocks only the completion of the next item.
// Reset clears the flags, received marks and active_entries at once; data and
// counters read as zero through per-entry valid bits, so no clearing pass runs.
// Identifiers and timeouts are undefined until loaded.
module can_rx_mailbox_timeout_monitor_top #(
	parameter int ENTRIES = rxmon_pkg::ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  rxmon_pkg::item_t                 item,
	output logic                             result_valid,
	input  logic                             result_stall,
	output rxmon_pkg::result_t               result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rxmon_pkg::ACTIVE_W-1:0]   cfg_data
);
	import rxmon_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_RDWAIT = 2'd2;
	localparam logic [1:0] ST_DONE   = 2'd3;

	logic [1:0]          state_q;
	item_t               item_q;
	logic [ACTIVE_W-1:0] active_q;
	logic [CW-1:0]       n_w;
	logic [CW-1:0]       ptr_q;
	logic                vld_s1;
	logic [IW-1:0]       idx_s1;
	logic [ENTRIES-1:0]  mark_q;
	logic [ENTRIES-1:0]  flag_q;
	logic                matched_q;
	logic [IDX_W-1:0]    midx_q;
	logic [DATA_W-1:0]   edata_q;
	logic                erx_q;
	logic                eto_q;
	logic                res_vld_q;
	result_t             res_q;
	logic [MAP_W-1:0]    tmap;

	logic                accept;
	logic                out_free;
	logic                issue;
	logic                hit;
	logic                tick_wr;
	logic                item_in_range;
	logic                held_in_range;

	logic                id_wr_en;
	logic [IW-1:0]       id_wr_addr;
	id_entry_t           id_wr_entry;
	logic                rd_en;
	logic [IW-1:0]       rd_addr;
	id_entry_t           id_rd;
	logic                dat_wr_en;
	data_entry_t         dat_wr_entry;
	data_entry_t         dat_rd;
	tick_res_t           tick_res;

	assign accept        = item_valid && !item_stall;
	assign item_stall    = (state_q != ST_IDLE);
	assign out_free      = !res_vld_q || !result_stall;
	assign cfg_ready     = 1'b1;
	assign item_in_range = (32'(item.entry_index) < ENTRIES);
	assign held_in_range = (32'(item_q.entry_index) < ENTRIES);

	// Clamp the active entry count to the table size
	assign n_w = (32'(active_q) > ENTRIES) ? CW'(ENTRIES) : CW'(active_q);

	// Issue one entry read per cycle while the walk has entries left
	assign issue = (state_q == ST_SCAN) && (ptr_q < n_w);
	assign hit   = vld_s1 && (item_q.func == FUNC_RECV) && (id_rd.id == item_q.frame_id);
	assign tick_wr = vld_s1 && (item_q.func == FUNC_TICK);

	// Share the read port between the walk and a read item
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ptr_q[IW-1:0];
		if (state_q == ST_IDLE) begin
			rd_en   = accept && (item.func == FUNC_READ) && item_in_range;
			rd_addr = IW'(item.entry_index);
		end else if (issue) begin
			rd_en = 1'b1;
		end
	end

	// Load writes go straight into the identifier memory at acceptance
	assign id_wr_en    = accept && (item.func == FUNC_LOAD) && item_in_range;
	assign id_wr_addr  = IW'(item.entry_index);
	assign id_wr_entry = '{id: item.frame_id, tmo: item.timeout_units};

	// Write back merged data on a hit, or on a tick the updated counter, cleared instead for a marked entry
	assign tick_res = tick_update(dat_rd.count, item_q.elapsed, id_rd.tmo);
	always_comb begin
		dat_wr_en    = hit || tick_wr;
		dat_wr_entry = dat_rd;
		if (hit) begin
			dat_wr_entry.data = merge_bytes(dat_rd.data, item_q.payload, item_q.byte_count);
		end else if (mark_q[idx_s1]) begin
			dat_wr_entry.count = '0;
		end else begin
			dat_wr_entry.count = tick_res.count;
		end
	end

	rxmon_id_ram #(
		.ENTRIES (ENTRIES),
		.IW      (IW)
	) u_id_ram (
		.clk      (clk),
		.wr_en    (id_wr_en),
		.wr_addr  (id_wr_addr),
		.wr_entry (id_wr_entry),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_entry (id_rd)
	);

	rxmon_data_ram #(
		.ENTRIES (ENTRIES),
		.IW      (IW)
	) u_data_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (dat_wr_en),
		.wr_addr  (idx_s1),
		.wr_entry (dat_wr_entry),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_entry (dat_rd)
	);

	// Hold the configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			active_q <= cfg_data;
		end
	end

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
	end

	// Sequence the item and the entry walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ptr_q     <= '0;
			vld_s1    <= 1'b0;
			matched_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					vld_s1 <= 1'b0;
					if (accept) begin
						ptr_q     <= '0;
						matched_q <= 1'b0;
						if (item.func == FUNC_LOAD) begin
							state_q <= ST_DONE;
						end else if (item.func == FUNC_READ) begin
							state_q <= ST_RDWAIT;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						ptr_q <= ptr_q + CW'(1);
					end
					vld_s1 <= issue && !hit;
					if (hit) begin
						matched_q <= 1'b1;
						state_q   <= ST_DONE;
					end else if (!vld_s1 && !issue) begin
						state_q <= ST_DONE;
					end
				end
				ST_RDWAIT: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Register the index of the issued entry for the compare stage
	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1 <= ptr_q[IW-1:0];
		end
	end

	// Set marks on a hit; clear or expire entries on a tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q <= '0;
			flag_q <= '0;
		end else begin
			if (hit) begin
				mark_q[idx_s1] <= 1'b1;
			end else if (tick_wr) begin
				if (mark_q[idx_s1]) begin
					mark_q[idx_s1] <= 1'b0;
					flag_q[idx_s1] <= 1'b0;
				end else if (tick_res.expired) begin
					flag_q[idx_s1] <= 1'b1;
				end
			end
		end
	end

	// Hold the per-item result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			midx_q  <= '0;
			edata_q <= '0;
			erx_q   <= 1'b0;
			eto_q   <= 1'b0;
		end else begin
			if (hit) begin
				midx_q <= IDX_W'(idx_s1);
			end
			if (state_q == ST_RDWAIT && held_in_range) begin
				edata_q <= dat_rd.data;
				erx_q   <= mark_q[IW'(item_q.entry_index)];
				eto_q   <= flag_q[IW'(item_q.entry_index)];
			end
		end
	end

	// Gather the timeout flags of the first sixteen entries
	for (genvar gk = 0; gk < MAP_W; gk++) begin : g_map
		if (gk < ENTRIES) begin : g_used
			assign tmap[gk] = flag_q[gk];
		end else begin : g_unused
			assign tmap[gk] = 1'b0;
		end
	end

	// Output register: load on completion, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			res_vld_q <= 1'b1;
		end else if (!result_stall) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			res_q.matched         <= matched_q;
			res_q.match_index     <= midx_q;
			res_q.timeout_map     <= tmap;
			res_q.entry_data      <= edata_q;
			res_q.entry_received  <= erx_q;
			res_q.entry_timed_out <= eto_q;
		end
	end

	assign result_valid = res_vld_q;
	assign result       = res_q;

	// A new result is only registered out of the completion state
	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside completion");

	// An accepted item always leaves the idle state
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("accepted item did not start");

	// The walk never runs past the active entries
	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (ptr_q <= n_w))
		else $error("walk pointer beyond active entries");

	// A pending entry in the compare stage is always an active one
	a_s1_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (32'(idx_s1) < 32'(n_w)))
		else $error("compare stage holds inactive entry");

	// A held result is not overwritten while stalled
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (state_q != ST_IDLE || $stable(result)))
		else $error("stalled result changed");

endmodule
